[sv/gpg_pkg.sv]
// ----------------------------------------------------------------------------
// gpg_pkg
// Shared types, constants and helpers of the grid potential gradient block.
// ----------------------------------------------------------------------------
package gpg_pkg;

    localparam int MAX_NX_DEF  = 256;
    localparam int MAX_NY_DEF  = 256;
    localparam int SW          = 32;            // sample width
    localparam int LANES       = 3;             // rows kept, one lane per row slot
    localparam int WORD_W      = SW * LANES;    // one memory word holds a column
    localparam int OFIFO_DEPTH = 4;

    // configuration register indexes
    localparam logic [1:0] REG_GRID_NX    = 2'd0;
    localparam logic [1:0] REG_GRID_NY    = 2'd1;
    localparam logic [1:0] REG_INV_TWO_DX = 2'd2;
    localparam logic [1:0] REG_INV_TWO_DY = 2'd3;

    // difference stencil: one-sided at the start, central, one-sided at the end
    typedef enum logic [1:0] {
        DT_START   = 2'd0,
        DT_CENTRAL = 2'd1,
        DT_END     = 2'd2
    } diff_t;

    typedef struct packed {
        logic [1:0] rot;
        logic [1:0] yslot;
        diff_t      xtype;
        diff_t      ytype;
        logic [7:0] x_index;
        logic [7:0] y_index;
        logic       last;
        logic       frame;
    } task_t;

    typedef struct packed {
        logic [7:0]        x_index;
        logic [7:0]        y_index;
        logic signed [31:0] e_x;
        logic signed [31:0] e_y;
        logic              last;
        logic              frame;
    } result_t;

    // (s + k) mod 3 for row slots
    function automatic logic [1:0] slot_add(logic [1:0] s, logic [1:0] k);
        logic [2:0] t;
        t = {1'b0, s} + {1'b0, k};
        return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    endfunction

    function automatic logic signed [SW-1:0] lane_of(logic [WORD_W-1:0] w, logic [1:0] s);
        logic signed [SW-1:0] v;
        unique case (s)
            2'd0:    v = w[0*SW +: SW];
            2'd1:    v = w[1*SW +: SW];
            default: v = w[2*SW +: SW];
        endcase
        return v;
    endfunction

endpackage

[sv/gpg_row_mem.sv]
// ----------------------------------------------------------------------------
// gpg_row_mem
// Column memory: one word per y holds the three kept rows, one lane per slot.
// One lane write and two registered reads per cycle, write-through on a hit.
// ----------------------------------------------------------------------------
module gpg_row_mem
    import gpg_pkg::*;
#(
    parameter int DEPTH = MAX_NY_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [1:0]               wr_lane,
    input  logic [SW-1:0]            wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WORD_W-1:0]        rd_data_a,
    output logic [WORD_W-1:0]        rd_data_b
);

    logic [WORD_W-1:0] row_mem [DEPTH];
    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;
    logic              fwd_a_reg;
    logic              fwd_b_reg;
    logic [1:0]        fwd_lane_reg;
    logic [SW-1:0]     fwd_data_reg;

    always_ff @(posedge aclk) begin
        for (int l = 0; l < LANES; l++) begin
            if (wr_en && wr_lane == 2'(l)) begin
                row_mem[wr_addr][SW*l +: SW] <= wr_data;
            end
        end
        rd_a_reg     <= row_mem[rd_addr_a];
        rd_b_reg     <= row_mem[rd_addr_b];
        fwd_lane_reg <= wr_lane;
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end else begin
            fwd_a_reg <= wr_en && (wr_addr == rd_addr_a);
            fwd_b_reg <= wr_en && (wr_addr == rd_addr_b);
        end
    end

    // patch in a lane written in the same cycle as the read
    always_comb begin
        rd_data_a = rd_a_reg;
        rd_data_b = rd_b_reg;
        for (int l = 0; l < LANES; l++) begin
            if (fwd_a_reg && fwd_lane_reg == 2'(l)) rd_data_a[SW*l +: SW] = fwd_data_reg;
            if (fwd_b_reg && fwd_lane_reg == 2'(l)) rd_data_b[SW*l +: SW] = fwd_data_reg;
        end
    end

endmodule

[sv/gpg_grad_calc.sv]
// ----------------------------------------------------------------------------
// gpg_grad_calc
// Three-stage datapath: stencil numerators, split multiplies, round and
// saturate to Q16.16.
// ----------------------------------------------------------------------------
module gpg_grad_calc
    import gpg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  task_t                 in_task,
    input  logic [WORD_W-1:0]     col0,
    input  logic [WORD_W-1:0]     col1,
    input  logic [WORD_W-1:0]     col2,
    input  logic signed [SW-1:0]  inv_dx,
    input  logic signed [SW-1:0]  inv_dy,
    output logic                  out_valid,
    output result_t               out_res
);

    function automatic logic signed [35:0] numer(diff_t t, logic signed [31:0] a,
                                                 logic signed [31:0] b, logic signed [31:0] c);
        logic signed [35:0] ea;
        logic signed [35:0] eb;
        logic signed [35:0] ec;
        logic signed [35:0] r;
        ea = 36'(a);
        eb = 36'(b);
        ec = 36'(c);
        unique case (t)
            DT_START:   r = (ea <<< 1) + ea - (eb <<< 2) + ec;
            DT_END:     r = (eb <<< 2) - ea - (ec <<< 1) - ec;
            DT_CENTRAL: r = ea - ec;
            default:    r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] round_sat(logic signed [51:0] p_hi,
                                                     logic signed [48:0] p_lo);
        logic signed [49:0] lo_r;
        logic signed [52:0] sum;
        logic signed [31:0] r;
        lo_r = 50'(p_lo) + 50'sd32768;
        sum  = 53'(p_hi) + 53'(lo_r >>> 16);
        if (sum > 53'sd2147483647)       r = 32'sh7FFFFFFF;
        else if (sum < -53'sd2147483648) r = 32'sh80000000;
        else                             r = 32'(sum);
        return r;
    endfunction

    logic [WORD_W-1:0]   colc;
    logic signed [35:0]  nx_num;
    logic signed [35:0]  ny_num;

    logic                s1_v_reg;
    task_t               s1_task_reg;
    logic signed [35:0]  s1_nx_reg;
    logic signed [35:0]  s1_ny_reg;

    logic                s2_v_reg;
    task_t               s2_task_reg;
    logic signed [51:0]  px_hi_reg;
    logic signed [48:0]  px_lo_reg;
    logic signed [51:0]  py_hi_reg;
    logic signed [48:0]  py_lo_reg;

    logic                out_v_reg;
    result_t             out_res_reg;

    // x stencil runs down column c, which is the start, middle or end column
    always_comb begin
        unique case (in_task.ytype)
            DT_START: colc = col0;
            DT_END:   colc = col2;
            default:  colc = col1;
        endcase
        nx_num = numer(in_task.xtype,
                       lane_of(colc, slot_add(in_task.rot, 2'd1)),
                       lane_of(colc, slot_add(in_task.rot, 2'd2)),
                       lane_of(colc, in_task.rot));
        ny_num = numer(in_task.ytype,
                       lane_of(col0, in_task.yslot),
                       lane_of(col1, in_task.yslot),
                       lane_of(col2, in_task.yslot));
    end

    always_ff @(posedge aclk) begin
        s1_task_reg <= in_task;
        s1_nx_reg   <= nx_num;
        s1_ny_reg   <= ny_num;

        // N*k = hi*k*2^16 + lo*k, lo unsigned 16 bits
        s2_task_reg <= s1_task_reg;
        px_hi_reg   <= signed'(s1_nx_reg[35:16]) * inv_dx;
        px_lo_reg   <= signed'({1'b0, s1_nx_reg[15:0]}) * inv_dx;
        py_hi_reg   <= signed'(s1_ny_reg[35:16]) * inv_dy;
        py_lo_reg   <= signed'({1'b0, s1_ny_reg[15:0]}) * inv_dy;

        out_res_reg.x_index <= s2_task_reg.x_index;
        out_res_reg.y_index <= s2_task_reg.y_index;
        out_res_reg.e_x     <= round_sat(px_hi_reg, px_lo_reg);
        out_res_reg.e_y     <= round_sat(py_hi_reg, py_lo_reg);
        out_res_reg.last    <= s2_task_reg.last;
        out_res_reg.frame   <= s2_task_reg.frame;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            s1_v_reg  <= in_valid;
            s2_v_reg  <= s1_v_reg;
            out_v_reg <= s2_v_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign out_res   = out_res_reg;

endmodule

[sv/gpg_out_fifo.sv]
// ----------------------------------------------------------------------------
// gpg_out_fifo
// Small result queue between the datapath and the result channel.
// ----------------------------------------------------------------------------
module gpg_out_fifo
    import gpg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    valid,
    output result_t data
);

    localparam int PW = $clog2(OFIFO_DEPTH);
    localparam int CW = $clog2(OFIFO_DEPTH + 1);

    result_t       entry_reg [OFIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop)      count_reg <= count_reg + CW'(1);
            else if (!push && pop) count_reg <= count_reg - CW'(1);
        end
    end

    assign valid = (count_reg != '0);
    assign data  = entry_reg[rd_ptr_reg];

endmodule

[sv/grid_potential_gradient.sv]
// ----------------------------------------------------------------------------
// grid_potential_gradient
// Rows 0 and 1: one sample per cycle. Later samples: each result takes a pair
// read, then a last read, the three columns fetched over the two read ports of
// the row memory; pair reads wait for a queue slot, and a sample is taken as the
// last result of the one before issues. From row 2 on a sample yields the result
// one row back, row 2 also that of row 0; the last row adds its own result one
// column back from its third sample on, and its corner points at its third and
// final samples. Reset clears counters, sequencer and queue, not the row memory.
// ----------------------------------------------------------------------------
module grid_potential_gradient
    import gpg_pkg::*;
#(
    parameter int MAX_NX = MAX_NX_DEF,
    parameter int MAX_NY = MAX_NY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_phi_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_x_index,
    output logic [7:0]         m_y_index,
    output logic signed [31:0] m_e_x,
    output logic signed [31:0] m_e_y,
    output logic               m_last_of_run,
    output logic               m_frame_done
);

    localparam int XW = $clog2(MAX_NX);
    localparam int YW = $clog2(MAX_NY);
    localparam int CW = $clog2(OFIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_PAIR = 2'b01,
        PH_LAST = 2'b10
    } phase_t;

    // configuration
    logic [8:0]         grid_nx_reg;
    logic [8:0]         grid_ny_reg;
    logic signed [31:0] inv_dx_reg;
    logic signed [31:0] inv_dy_reg;
    logic [31:0]        nx_eff;
    logic [31:0]        ny_eff;
    logic [XW-1:0]      nx_last;
    logic [YW-1:0]      ny_last;
    logic               cfg_wr;
    logic               geom_wr;

    // raster position
    logic [XW-1:0] x_cnt_reg;
    logic [YW-1:0] y_cnt_reg;
    logic [1:0]    rot_reg;
    logic          wrap;
    logic [XW-1:0] cur_x;
    logic [YW-1:0] cur_y;
    logic [1:0]    cur_rot;
    logic [XW-1:0] x_adv;
    logic [YW-1:0] y_adv;
    logic [1:0]    rot_adv;
    logic          x_is_last;
    logic [4:0]    new_mask;
    logic          s_acc;

    // item in work
    logic               ib_v_reg;
    logic signed [31:0] ib_sample_reg;
    logic [XW-1:0]      ib_x_reg;
    logic [YW-1:0]      ib_y_reg;
    logic [1:0]         ib_rot_reg;
    logic [4:0]         mask_reg;
    phase_t             phase_reg;
    logic               wr_done_reg;

    logic [4:0]    cur_bit;
    logic [4:0]    rest;
    logic          has_task;
    logic [YW-1:0] col_c;
    logic [YW-1:0] col0;
    logic [YW-1:0] col1;
    logic [YW-1:0] col2;
    task_t         cur_task;
    logic          credit_ok;
    logic          issue_pair;
    logic          issue_last;
    logic          done_now;
    logic          mem_wr;
    logic [CW-1:0] cnt_reg;

    // memory and datapath
    logic [YW-1:0]     rd_addr_a;
    logic [WORD_W-1:0] rd_data_a;
    logic [WORD_W-1:0] rd_data_b;
    logic              pair_d1_reg;
    logic [WORD_W-1:0] hold_a_reg;
    logic [WORD_W-1:0] hold_b_reg;
    logic              task_v_d1_reg;
    task_t             task_d1_reg;
    logic              calc_valid;
    result_t           calc_res;
    result_t           out_res;
    logic              pop;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign geom_wr   = cfg_wr && (cfg_index == REG_GRID_NX || cfg_index == REG_GRID_NY);

    always_comb begin
        if (grid_nx_reg < 9'd3)                   nx_eff = 32'd3;
        else if (32'(grid_nx_reg) > 32'(MAX_NX))  nx_eff = 32'(MAX_NX);
        else                                      nx_eff = 32'(grid_nx_reg);
        if (grid_ny_reg < 9'd3)                   ny_eff = 32'd3;
        else if (32'(grid_ny_reg) > 32'(MAX_NY))  ny_eff = 32'(MAX_NY);
        else                                      ny_eff = 32'(grid_ny_reg);
        nx_last = XW'(nx_eff - 32'd1);
        ny_last = YW'(ny_eff - 32'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_nx_reg <= 9'd256;
            grid_ny_reg <= 9'd256;
            inv_dx_reg  <= 32'sd65536;
            inv_dy_reg  <= 32'sd65536;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_GRID_NX:    grid_nx_reg <= cfg_data[8:0];
                REG_GRID_NY:    grid_ny_reg <= cfg_data[8:0];
                REG_INV_TWO_DX: inv_dx_reg  <= cfg_data;
                REG_INV_TWO_DY: inv_dy_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // position of the arriving sample, its result set and the next position
    always_comb begin
        wrap    = (x_cnt_reg > nx_last) || (y_cnt_reg > ny_last);
        cur_x   = wrap ? '0 : x_cnt_reg;
        cur_y   = wrap ? '0 : y_cnt_reg;
        cur_rot = wrap ? '0 : rot_reg;
        x_is_last = (cur_x == nx_last);
        new_mask  = '0;
        if (cur_x >= XW'(2)) begin
            new_mask[0] = (cur_x == XW'(2));
            new_mask[1] = 1'b1;
            new_mask[2] = x_is_last && (cur_y == YW'(2));
            new_mask[3] = x_is_last && (cur_y >= YW'(2));
            new_mask[4] = x_is_last && (cur_y == ny_last);
        end
        if (cur_y == ny_last) begin
            y_adv = '0;
            if (x_is_last) begin
                x_adv   = '0;
                rot_adv = '0;
            end else begin
                x_adv   = cur_x + XW'(1);
                rot_adv = slot_add(cur_rot, 2'd1);
            end
        end else begin
            y_adv   = cur_y + YW'(1);
            x_adv   = cur_x;
            rot_adv = cur_rot;
        end
    end

    assign s_acc = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_cnt_reg <= '0;
            y_cnt_reg <= '0;
            rot_reg   <= '0;
        end else if (geom_wr) begin
            x_cnt_reg <= '0;
            y_cnt_reg <= '0;
            rot_reg   <= '0;
        end else if (s_acc) begin
            x_cnt_reg <= x_adv;
            y_cnt_reg <= y_adv;
            rot_reg   <= rot_adv;
        end
    end

    // current result of the item: lowest pending bit of the mask
    //   bit 0: (0, y)     bit 1: (x-1, y)
    //   bit 2: (x, 0)     bit 3: (x, y-1)     bit 4: (x, y)
    always_comb begin
        cur_bit  = mask_reg & (~mask_reg + 5'd1);
        rest     = mask_reg & ~cur_bit;
        has_task = (mask_reg != '0);

        if (cur_bit[2])      col_c = '0;
        else if (cur_bit[3]) col_c = ib_y_reg - YW'(1);
        else                 col_c = ib_y_reg;

        cur_task.rot = ib_rot_reg;
        if (col_c == '0) begin
            cur_task.ytype = DT_START;
            col0 = '0;
            col1 = YW'(1);
            col2 = YW'(2);
        end else if (col_c == ny_last) begin
            cur_task.ytype = DT_END;
            col0 = ny_last - YW'(2);
            col1 = ny_last - YW'(1);
            col2 = ny_last;
        end else begin
            cur_task.ytype = DT_CENTRAL;
            col0 = col_c - YW'(1);
            col1 = col_c;
            col2 = col_c + YW'(1);
        end

        if (cur_bit[0]) begin
            cur_task.yslot   = slot_add(ib_rot_reg, 2'd1);
            cur_task.xtype   = DT_START;
            cur_task.x_index = '0;
        end else if (cur_bit[1]) begin
            cur_task.yslot   = slot_add(ib_rot_reg, 2'd2);
            cur_task.xtype   = DT_CENTRAL;
            cur_task.x_index = 8'(ib_x_reg - XW'(1));
        end else begin
            cur_task.yslot   = ib_rot_reg;
            cur_task.xtype   = DT_END;
            cur_task.x_index = 8'(ib_x_reg);
        end
        cur_task.y_index = 8'(col_c);
        cur_task.last    = (rest == '0);
        cur_task.frame   = cur_bit[4];
    end

    assign credit_ok  = (cnt_reg < CW'(OFIFO_DEPTH));
    assign issue_pair = ib_v_reg && has_task && (phase_reg == PH_PAIR) && credit_ok;
    assign issue_last = ib_v_reg && has_task && (phase_reg == PH_LAST);
    assign done_now   = ib_v_reg && (!has_task || (issue_last && rest == '0));
    assign mem_wr     = (ib_v_reg && !has_task) || (issue_pair && !wr_done_reg);
    assign s_ready    = !ib_v_reg || done_now;
    assign rd_addr_a  = (phase_reg == PH_LAST) ? col2 : col0;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            ib_sample_reg <= s_phi_sample;
            ib_x_reg      <= cur_x;
            ib_y_reg      <= cur_y;
            ib_rot_reg    <= cur_rot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ib_v_reg    <= 1'b0;
            mask_reg    <= '0;
            phase_reg   <= PH_PAIR;
            wr_done_reg <= 1'b0;
        end else if (s_acc) begin
            ib_v_reg    <= 1'b1;
            mask_reg    <= new_mask;
            phase_reg   <= PH_PAIR;
            wr_done_reg <= 1'b0;
        end else if (done_now) begin
            ib_v_reg <= 1'b0;
            mask_reg <= '0;
        end else if (issue_pair) begin
            phase_reg   <= PH_LAST;
            wr_done_reg <= 1'b1;
        end else if (issue_last) begin
            phase_reg <= PH_PAIR;
            mask_reg  <= rest;
        end
    end

    // one queue slot reserved per result until it leaves the block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (issue_pair && !pop) begin
            cnt_reg <= cnt_reg + CW'(1);
        end else if (!issue_pair && pop) begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    gpg_row_mem #(
        .DEPTH (MAX_NY)
    ) u_row_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (mem_wr),
        .wr_addr   (ib_y_reg),
        .wr_lane   (ib_rot_reg),
        .wr_data   (ib_sample_reg),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (col1),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // hold the first two columns until the third arrives
    always_ff @(posedge aclk) begin
        if (pair_d1_reg) begin
            hold_a_reg <= rd_data_a;
            hold_b_reg <= rd_data_b;
        end
        if (issue_last) task_d1_reg <= cur_task;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_d1_reg   <= 1'b0;
            task_v_d1_reg <= 1'b0;
        end else begin
            pair_d1_reg   <= issue_pair;
            task_v_d1_reg <= issue_last;
        end
    end

    gpg_grad_calc u_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (task_v_d1_reg),
        .in_task   (task_d1_reg),
        .col0      (hold_a_reg),
        .col1      (hold_b_reg),
        .col2      (rd_data_a),
        .inv_dx    (inv_dx_reg),
        .inv_dy    (inv_dy_reg),
        .out_valid (calc_valid),
        .out_res   (calc_res)
    );

    assign pop = m_valid && m_ready;

    gpg_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (calc_valid),
        .push_data (calc_res),
        .pop       (pop),
        .valid     (m_valid),
        .data      (out_res)
    );

    assign m_x_index     = out_res.x_index;
    assign m_y_index     = out_res.y_index;
    assign m_e_x         = out_res.e_x;
    assign m_e_y         = out_res.e_y;
    assign m_last_of_run = out_res.last;
    assign m_frame_done  = out_res.frame;

endmodule

[sim/grid_potential_gradient_test.sv]
// ----------------------------------------------------------------------------
// grid_potential_gradient_test
// Streams potential frames into the gradient block and checks every E-field
// result, in order, against a behavioral predictor kept in this testbench.
// ----------------------------------------------------------------------------
module grid_potential_gradient_test;
    import gpg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_LEN     = 256;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 24;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_phi_sample;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_x_index;
    logic [7:0]         m_y_index;
    logic signed [31:0] m_e_x;
    logic signed [31:0] m_e_y;
    logic               m_last_of_run;
    logic               m_frame_done;

    grid_potential_gradient dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_phi_sample  (s_phi_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_x_index     (m_x_index),
        .m_y_index     (m_y_index),
        .m_e_x         (m_e_x),
        .m_e_y         (m_e_y),
        .m_last_of_run (m_last_of_run),
        .m_frame_done  (m_frame_done)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic signed [31:0] phi_rows [3][ROW_LEN];
    int unsigned        x_pos, y_pos, slot_cur;
    int unsigned        rows_used, cols_used;
    logic signed [31:0] scale_x, scale_y;
    result_t            gradient_q [$];

    int unsigned errors;
    int unsigned results_seen;
    int unsigned phi_sent;
    int unsigned idle_cycles;

    // sender and receiver idling
    bit              sender_idles;
    int unsigned     burst_left;
    logic [15:0]     stall_pattern;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic int unsigned clamp_dim(logic [8:0] r);
        if (r < 3) return 3;
        if (r > ROW_LEN) return ROW_LEN;
        return r;
    endfunction

    function automatic longint phi_at(int unsigned r, int unsigned c);
        int unsigned s;
        s = (slot_cur + 3 - ((x_pos - r) % 3)) % 3;
        return longint'(phi_rows[s][c]);
    endfunction

    function automatic logic signed [31:0] scale_sat(longint num, logic signed [31:0] k);
        logic signed [71:0] n;
        logic signed [71:0] kk;
        logic signed [71:0] p;
        n  = num;
        kk = k;
        p  = (n * kk + 72'sd32768) >>> 16;
        if (p > 72'sd2147483647) return 32'sh7fffffff;
        if (p < -72'sd2147483648) return 32'sh80000000;
        return p[31:0];
    endfunction

    function automatic void push_gradient(int unsigned r, int unsigned c);
        longint  nxn, nyn;
        result_t res;
        if (r == 0)
            nxn = 3 * phi_at(0, c) - 4 * phi_at(1, c) + phi_at(2, c);
        else if (r == rows_used - 1)
            nxn = -phi_at(r - 2, c) + 4 * phi_at(r - 1, c) - 3 * phi_at(r, c);
        else
            nxn = phi_at(r - 1, c) - phi_at(r + 1, c);
        if (c == 0)
            nyn = 3 * phi_at(r, 0) - 4 * phi_at(r, 1) + phi_at(r, 2);
        else if (c == cols_used - 1)
            nyn = -phi_at(r, c - 2) + 4 * phi_at(r, c - 1) - 3 * phi_at(r, c);
        else
            nyn = phi_at(r, c - 1) - phi_at(r, c + 1);
        res.x_index = r[7:0];
        res.y_index = c[7:0];
        res.e_x     = scale_sat(nxn, scale_x);
        res.e_y     = scale_sat(nyn, scale_y);
        res.last    = 1'b0;
        res.frame   = (r == rows_used - 1) && (c == cols_used - 1);
        gradient_q = {gradient_q, res};
    endfunction

    function automatic void predict_gradient(logic signed [31:0] v);
        int unsigned before_cnt;
        before_cnt = gradient_q.size();
        phi_rows[slot_cur][y_pos] = v;
        if (x_pos >= 2) begin
            if (x_pos == 2) push_gradient(0, y_pos);
            push_gradient(x_pos - 1, y_pos);
            if (x_pos == rows_used - 1) begin
                if (y_pos == 2) push_gradient(x_pos, 0);
                if (y_pos >= 2) push_gradient(x_pos, y_pos - 1);
                if (y_pos == cols_used - 1) push_gradient(x_pos, y_pos);
            end
        end
        if (gradient_q.size() > before_cnt)
            gradient_q[gradient_q.size() - 1].last = 1'b1;
        y_pos++;
        if (y_pos >= cols_used) begin
            y_pos    = 0;
            slot_cur = (slot_cur + 1) % 3;
            x_pos++;
            if (x_pos >= rows_used) begin
                x_pos    = 0;
                slot_cur = 0;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what);
        errors++;
        if (errors <= 20) $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (gradient_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d",
                                          m_x_index, m_y_index));
            end else begin
                want = gradient_q.pop_front();
                if (m_x_index !== want.x_index || m_y_index !== want.y_index ||
                    m_e_x !== want.e_x || m_e_y !== want.e_y ||
                    m_last_of_run !== want.last || m_frame_done !== want.frame)
                    report_mismatch($sformatf(
                        "got (%0d,%0d) ex=%h ey=%h l=%b f=%b want (%0d,%0d) ex=%h ey=%h l=%b f=%b",
                        m_x_index, m_y_index, m_e_x, m_e_y, m_last_of_run, m_frame_done,
                        want.x_index, want.y_index, want.e_x, want.e_y, want.last,
                        want.frame));
            end
        end
    end

    // receiver stalls on a rotating pattern
    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready       <= stall_pattern[0];
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress, %0d results pending", gradient_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_GRID_NX, REG_GRID_NY: begin
                if (idx == REG_GRID_NX) rows_used = clamp_dim(data[8:0]);
                else cols_used = clamp_dim(data[8:0]);
                x_pos    = 0;
                y_pos    = 0;
                slot_cur = 0;
            end
            REG_INV_TWO_DX: scale_x = data;
            default:        scale_y = data;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_phi(logic signed [31:0] v);
        int unsigned gap;
        s_valid      = 1'b1;
        s_phi_sample = v;
        do @(posedge aclk); while (!s_ready);
        predict_gradient(v);
        phi_sent++;
        @(negedge aclk);
        if (sender_idles) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 7);
                burst_left = $urandom_range(1, 12);
                s_valid    = 1'b0;
                repeat (gap) @(negedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // hold off until every expected result has come, then let the pipe settle
    task automatic wait_drain();
        s_valid = 1'b0;
        while (gradient_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    function automatic logic signed [31:0] random_phi();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 8191)) - 4096;
            2:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom) >>> $urandom_range(4, 20);
        endcase
    endfunction

    task automatic set_geometry(logic [8:0] nx, logic [8:0] ny);
        write_reg(REG_GRID_NX, {23'd0, nx});
        write_reg(REG_GRID_NY, {23'd0, ny});
    endtask

    task automatic send_frame(int unsigned n);
        repeat (n) send_phi(random_phi());
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_smallest_grid_extremes();
        logic signed [31:0] pts [9];
        sender_idles  = 1'b0;
        stall_pattern = 16'hffff;
        pts = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'shffffffff, 32'sh00010000,
                32'sh80000000, 32'sh7fffffff, 32'sh0, 32'sh55555555};
        // dimensions below three act as three
        set_geometry(9'd0, 9'd2);
        foreach (pts[i]) send_phi(pts[i]);
        wait_drain();
    endtask

    task automatic test_scale_extremes();
        logic signed [31:0] pts [9];
        sender_idles  = 1'b1;
        stall_pattern = 16'b1011_0110_1110_0101;
        pts = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh1, 32'sh0,
                32'shfffffffe, 32'sh7fffffff, 32'sh80000000, 32'sh00008000};
        write_reg(REG_INV_TWO_DX, 32'h80000000);
        write_reg(REG_INV_TWO_DY, 32'h7fffffff);
        foreach (pts[i]) send_phi(pts[i]);
        wait_drain();
        write_reg(REG_INV_TWO_DX, 32'h00000000);
        write_reg(REG_INV_TWO_DY, 32'hffff8000);
        set_geometry(9'd1, 9'd3);
        send_frame(5);
        wait_drain();
    endtask

    task automatic test_widest_row();
        sender_idles  = 1'b1;
        stall_pattern = 16'b0111_1101_1011_1110;
        write_reg(REG_INV_TWO_DX, 32'h00010000);
        write_reg(REG_INV_TWO_DY, 32'h00000400);
        // oversize width clamps to the maximum; stay inside the first row
        set_geometry(9'd3, 9'd300);
        send_frame(20);
        wait_drain();
    endtask

    task automatic test_tallest_frame();
        sender_idles  = 1'b0;
        stall_pattern = 16'b1100_1100_1111_0000;
        set_geometry(9'd511, 9'd3);
        // partial frame only: the geometry write below restarts it
        send_frame(18);
        wait_drain();
    endtask

    task automatic test_random_frames();
        int unsigned target;
        target = phi_sent + 55;
        while (phi_sent < target) begin
            sender_idles  = $urandom_range(0, 3) != 0;
            stall_pattern = $urandom_range(0, 2) == 0 ? 16'hffff : 16'($urandom) | 16'h0101;
            write_reg(REG_INV_TWO_DX, $urandom_range(0, 1) ? $urandom
                                      : 32'($urandom_range(0, 32'h40000)));
            write_reg(REG_INV_TWO_DY, $urandom_range(0, 1) ? $urandom
                                      : 32'($urandom_range(0, 32'h40000)));
            set_geometry(9'($urandom_range(3, 6)), 9'($urandom_range(3, 7)));
            if ($urandom_range(0, 4) == 0)
                send_frame($urandom_range(1, rows_used * cols_used));
            else
                send_frame(rows_used * cols_used * $urandom_range(1, 2));
            wait_drain();
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_GRID_NX;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_phi_sample  = '0;
        m_ready       = 1'b0;
        stall_pattern = 16'hffff;
        errors        = 0;
        results_seen  = 0;
        phi_sent      = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        sender_idles  = 1'b0;
        x_pos         = 0;
        y_pos         = 0;
        slot_cur      = 0;
        rows_used     = ROW_LEN;
        cols_used     = ROW_LEN;
        scale_x       = 32'sh00010000;
        scale_y       = 32'sh00010000;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_smallest_grid_extremes();
        test_scale_extremes();
        test_widest_row();
        test_tallest_frame();
        test_random_frames();

        $display("covered %0d samples and %0d results over clamped, minimum and random grids,",
                 phi_sent, results_seen);
        $display("with full-scale scales and samples, sender gaps and receiver stalls");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
sv/gpg_pkg.sv
sv/gpg_row_mem.sv
sv/gpg_grad_calc.sv
sv/gpg_out_fifo.sv
sv/grid_potential_gradient.sv
sim/grid_potential_gradient_test.sv
